### hdl/bbtq_pkg.sv
// Package for the beam-break trigger qualifier: item structs, codes and
// configuration defaults. It has no dependencies.
package bbtq_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int TS_W              = 32;
  localparam int GAP_W             = 24;
  localparam int LONG_W            = 26;
  localparam int NOISE_W           = 8;
  localparam int CFG_DATA_W        = 26;
  localparam int CFG_IDX_W         = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENVELOPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIND_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_WINDOW = 3'd5;

  localparam logic [GAP_W-1:0]   MIN_GAP_RESET      = 24'd10000;
  localparam logic [LONG_W-1:0]  MAX_ENVELOPE_RESET = 26'd200000;
  localparam logic [LONG_W-1:0]  BLIND_TIME_RESET   = 26'd200000;
  localparam logic [NOISE_W-1:0] NOISE_LIMIT_RESET  = 8'd10;
  localparam logic [LONG_W-1:0]  NOISE_WINDOW_RESET = 26'd1000000;
  localparam logic [NOISE_W-1:0] NOISE_COUNT_MAX    = 8'd255;

  localparam logic [2:0] FLAGS_NONE = 3'b000;
  localparam logic [2:0] FLAGS_ALL  = 3'b111;
  localparam int FLAG_OUT_EN  = 0;
  localparam int FLAG_OUT_LVL = 1;
  localparam int FLAG_MASKED  = 2;

  typedef enum logic [1:0] {
    ST_FALLING = 2'd0,
    ST_RISING  = 2'd1,
    ST_NOISE   = 2'd2
  } beam_status_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TRIGGER = 2'd1,
    EV_NOISE   = 2'd2
  } event_kind_e;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp;
    logic            edge_rising;
    logic            from_external;
    logic            pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      event_kind;
    logic [TS_W-1:0] event_time;
    logic            ext_out_enable;
    logic            ext_out_level;
    logic            ext_inputs_masked;
  } out_item_t;

endpackage

### hdl/beam_break_trigger_qualifier.sv
// Top level of the beam-break trigger qualifier: edge and tick processing,
// configuration registers and a two-entry result queue. Depends on bbtq_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_item_i (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Each accepted item queues one result; one item per cycle unless stalled.
// The state update is a single pass of subtract, saturating add and compare.
// A two-entry result queue lets items enter while one result is stalled;
// in_stall_o rises only when both entries are full.
// Reset clears all state but the queue entries and loads config defaults.
module beam_break_trigger_qualifier
  import bbtq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int TW = TIME_BITS;
  localparam int CW = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  logic               enable_q;
  logic [GAP_W-1:0]   min_gap_q;
  logic [LONG_W-1:0]  max_env_q;
  logic [LONG_W-1:0]  blind_time_q;
  logic [NOISE_W-1:0] noise_limit_q;
  logic [LONG_W-1:0]  noise_window_q;

  logic [TW-1:0]      last_q, last_d;
  logic [TW-1:0]      rise_q, rise_d;
  logic [TW-1:0]      fall_q, fall_d;
  logic [TW-1:0]      present_q, present_d;
  logic [TW-1:0]      absent_q, absent_d;
  logic               rise_seen_q, rise_seen_d;
  beam_status_e       status_q, status_d;
  logic [NOISE_W-1:0] noise_cnt_q, noise_cnt_d;
  logic [TW-1:0]      blind_start_q, blind_start_d;
  logic               blind_run_q, blind_run_d;
  logic [TW-1:0]      win_start_q, win_start_d;
  logic               win_run_q, win_run_d;
  logic [2:0]         flags_q, flags_d;

  out_item_t          ent_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  logic               in_acc, out_acc;
  logic [TW-1:0]      now, dur, envelope;
  logic [TW-1:0]      blind_since, win_since;
  logic [TW:0]        psum, asum;
  logic [TW-1:0]      present_sat, absent_sat;
  logic [NOISE_W-1:0] cnt_inc;
  logic               blind_exp, win_exp, duty, settled;
  event_kind_e        kind;
  logic [63:0]        rise_wide;
  out_item_t          res;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_item_o  = ent_q[rd_ptr_q];

  assign now         = TW'(in_item_i.timestamp);
  assign dur         = now - last_q;
  assign envelope    = rise_seen_q ? (fall_q - rise_q) : '0;
  assign blind_since = now - blind_start_q;
  assign win_since   = now - win_start_q;
  assign psum        = {1'b0, present_q} + {1'b0, dur};
  assign asum        = {1'b0, absent_q} + {1'b0, dur};
  assign present_sat = psum[TW] ? TMAX : psum[TW-1:0];
  assign absent_sat  = asum[TW] ? TMAX : asum[TW-1:0];
  assign cnt_inc     = (noise_cnt_q == NOISE_COUNT_MAX) ? noise_cnt_q : noise_cnt_q + 8'd1;
  assign blind_exp   = !blind_run_q || (CW'(blind_since) >= CW'(blind_time_q));
  assign win_exp     = !win_run_q || (CW'(win_since) >= CW'(noise_window_q));
  assign duty        = absent_q > present_q;
  assign settled     = CW'(dur) >= CW'(min_gap_q);
  assign rise_wide   = 64'(rise_q);

  always_comb begin
    last_d        = last_q;
    rise_d        = rise_q;
    fall_d        = fall_q;
    present_d     = present_q;
    absent_d      = absent_q;
    rise_seen_d   = rise_seen_q;
    status_d      = status_q;
    noise_cnt_d   = noise_cnt_q;
    blind_start_d = blind_start_q;
    blind_run_d   = blind_run_q;
    win_start_d   = win_start_q;
    win_run_d     = win_run_q;
    flags_d       = flags_q;
    kind          = EV_NONE;
    res.event_time = '0;
    if (in_item_i.operation == OP_EDGE) begin
      if (!((!enable_q && !in_item_i.from_external) || status_q == ST_NOISE)) begin
        last_d = now;
        if (in_item_i.edge_rising) begin
          if (!rise_seen_q) begin
            rise_seen_d = 1'b1;
            rise_d      = now;
            fall_d      = now;
            if (!in_item_i.from_external) begin
              flags_d = FLAGS_ALL;
            end
          end else begin
            present_d = present_sat;
          end
          status_d = ST_RISING;
        end else begin
          fall_d = now;
          if (rise_seen_q) begin
            absent_d = absent_sat;
          end
          status_d = ST_FALLING;
          if (CW'(dur) < CW'(min_gap_q)) begin
            noise_cnt_d = cnt_inc;
            if (cnt_inc > noise_limit_q) begin
              status_d = ST_NOISE;
              kind     = EV_NOISE;
            end
          end
        end
      end
    end else begin
      if (rise_seen_q && settled && status_q == ST_FALLING) begin
        if (CW'(envelope) >= CW'(min_gap_q) && CW'(envelope) < CW'(max_env_q) && duty &&
            blind_exp) begin
          kind           = EV_TRIGGER;
          res.event_time = rise_wide[TS_W-1:0];
          blind_start_d  = now;
          blind_run_d    = 1'b1;
        end
        flags_d     = FLAGS_NONE;
        present_d   = '0;
        absent_d    = '0;
        fall_d      = '0;
        rise_d      = '0;
        rise_seen_d = 1'b0;
      end
      if (win_exp) begin
        win_start_d = now;
        win_run_d   = 1'b1;
        noise_cnt_d = '0;
        if (status_q == ST_NOISE) begin
          status_d = in_item_i.pin_level ? ST_RISING : ST_FALLING;
        end
      end
    end
    res.event_kind        = kind;
    res.ext_out_enable    = flags_d[FLAG_OUT_EN];
    res.ext_out_level     = flags_d[FLAG_OUT_LVL];
    res.ext_inputs_masked = flags_d[FLAG_MASKED];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      min_gap_q      <= MIN_GAP_RESET;
      max_env_q      <= MAX_ENVELOPE_RESET;
      blind_time_q   <= BLIND_TIME_RESET;
      noise_limit_q  <= NOISE_LIMIT_RESET;
      noise_window_q <= NOISE_WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:       enable_q       <= cfg_wdata_i[0];
        CFG_MIN_GAP:      min_gap_q      <= cfg_wdata_i[GAP_W-1:0];
        CFG_MAX_ENVELOPE: max_env_q      <= cfg_wdata_i;
        CFG_BLIND_TIME:   blind_time_q   <= cfg_wdata_i;
        CFG_NOISE_LIMIT:  noise_limit_q  <= cfg_wdata_i[NOISE_W-1:0];
        CFG_NOISE_WINDOW: noise_window_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q        <= '0;
      rise_q        <= '0;
      fall_q        <= '0;
      present_q     <= '0;
      absent_q      <= '0;
      rise_seen_q   <= 1'b0;
      status_q      <= ST_FALLING;
      noise_cnt_q   <= '0;
      blind_start_q <= '0;
      blind_run_q   <= 1'b0;
      win_start_q   <= '0;
      win_run_q     <= 1'b0;
      flags_q       <= FLAGS_NONE;
    end else if (in_acc) begin
      last_q        <= last_d;
      rise_q        <= rise_d;
      fall_q        <= fall_d;
      present_q     <= present_d;
      absent_q      <= absent_d;
      rise_seen_q   <= rise_seen_d;
      status_q      <= status_d;
      noise_cnt_q   <= noise_cnt_d;
      blind_start_q <= blind_start_d;
      blind_run_q   <= blind_run_d;
      win_start_q   <= win_start_d;
      win_run_q     <= win_run_d;
      flags_q       <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_acc) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (in_acc && !out_acc) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!in_acc && out_acc) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ent_q[wr_ptr_q] <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("result queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind == EV_TRIGGER |=> blind_run_q && !rise_seen_q && blind_start_q == $past(now))
    else $error("trigger did not arm the blind timer and clear tracking");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rise_seen_q |-> flags_q == FLAGS_NONE)
    else $error("external drive flags set without an envelope");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && status_q != ST_NOISE |=> (status_q == ST_NOISE) == ($past(kind) == EV_NOISE))
    else $error("noise lockout entered without a noise event");

endmodule
